// ===== hdl/rs_pkg.sv =====
// Shared types and constants for the rectangle subtraction block.
// Used by every module under hdl/; depends on nothing else.
package rs_pkg;

    localparam int unsigned COORD_W = 16;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord base_min_x;
        t_coord base_min_y;
        t_coord base_max_x;
        t_coord base_max_y;
        t_coord cut_min_x;
        t_coord cut_min_y;
        t_coord cut_max_x;
        t_coord cut_max_y;
    } t_in_item;

    typedef struct packed {
        t_coord piece_min_x;
        t_coord piece_min_y;
        t_coord piece_max_x;
        t_coord piece_max_y;
        logic   empty_res;
        logic   last;
    } t_out_item;

    // Kinds of result an item can produce, in the order they are emitted.
    localparam int unsigned NUM_KINDS = 6;
    localparam int unsigned KIND_W    = $clog2(NUM_KINDS);

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [NUM_KINDS-1:0] t_kind_mask;

    localparam t_kind KIND_LEFT   = t_kind'(0);
    localparam t_kind KIND_RIGHT  = t_kind'(1);
    localparam t_kind KIND_BOTTOM = t_kind'(2);
    localparam t_kind KIND_TOP    = t_kind'(3);
    localparam t_kind KIND_WHOLE  = t_kind'(4);
    localparam t_kind KIND_EMPTY  = t_kind'(5);

    // Classified item as handed from the front end to the emitter.
    typedef struct packed {
        t_coord     bx0;
        t_coord     by0;
        t_coord     bx1;
        t_coord     by1;
        t_coord     ix0;
        t_coord     iy0;
        t_coord     ix1;
        t_coord     iy1;
        t_kind_mask mask;
    } t_desc;

endpackage

// ===== hdl/rs_front.sv =====
// Front end: accepts input transactions, forms the intersection and decides
// which pieces remain. Depends on rs_pkg.
module rs_front
    import rs_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_desc    o_q_desc
);

    logic       clear;
    t_coord     ix0;
    t_coord     iy0;
    t_coord     ix1;
    t_coord     iy1;
    t_kind_mask mask;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        clear = (i_item.base_max_x <= i_item.cut_min_x) ||
                (i_item.cut_max_x  <= i_item.base_min_x) ||
                (i_item.base_max_y <= i_item.cut_min_y) ||
                (i_item.cut_max_y  <= i_item.base_min_y);

        ix0 = (i_item.cut_min_x > i_item.base_min_x) ? i_item.cut_min_x : i_item.base_min_x;
        iy0 = (i_item.cut_min_y > i_item.base_min_y) ? i_item.cut_min_y : i_item.base_min_y;
        ix1 = (i_item.cut_max_x < i_item.base_max_x) ? i_item.cut_max_x : i_item.base_max_x;
        iy1 = (i_item.cut_max_y < i_item.base_max_y) ? i_item.cut_max_y : i_item.base_max_y;

        mask = '0;
        if (clear) begin
            mask[KIND_WHOLE] = 1'b1;
        end else begin
            // A strip exists exactly when the cutter edge lies strictly inside the base.
            mask[KIND_LEFT]   = i_item.cut_min_x > i_item.base_min_x;
            mask[KIND_RIGHT]  = i_item.cut_max_x < i_item.base_max_x;
            mask[KIND_BOTTOM] = i_item.cut_min_y > i_item.base_min_y;
            mask[KIND_TOP]    = i_item.cut_max_y < i_item.base_max_y;
            mask[KIND_EMPTY]  = !(mask[KIND_LEFT] || mask[KIND_RIGHT] ||
                                  mask[KIND_BOTTOM] || mask[KIND_TOP]);
        end

        o_q_desc.bx0  = i_item.base_min_x;
        o_q_desc.by0  = i_item.base_min_y;
        o_q_desc.bx1  = i_item.base_max_x;
        o_q_desc.by1  = i_item.base_max_y;
        o_q_desc.ix0  = ix0;
        o_q_desc.iy0  = iy0;
        o_q_desc.ix1  = ix1;
        o_q_desc.iy1  = iy1;
        o_q_desc.mask = mask;
    end

endmodule

// ===== hdl/rs_queue.sv =====
// Two-entry queue of classified items between the front end and the emitter.
// Depends on rs_pkg.
module rs_queue
    import rs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic [PTR_W:0]   n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== hdl/rs_back.sv =====
// Emitter: walks the remaining pieces of one classified item, one result per
// cycle while the output is accepted, into a registered output. Depends on rs_pkg.
module rs_back
    import rs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_desc     i_q_desc,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_result
);

    t_desc      r_desc;
    t_kind_mask r_mask;
    logic       r_busy;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       out_load;
    logic       emit;
    t_kind      pick;
    t_kind_mask rest;
    logic       last;
    t_out_item  piece;

    assign out_load    = !r_out_valid || i_out_ready;
    assign emit        = r_busy && out_load;
    assign o_q_pop     = i_q_valid && (!r_busy || (emit && last));
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Lowest set bit of the mask is the next piece in emission order.
    always_comb begin
        pick = KIND_EMPTY;
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                pick = t_kind'(k);
            end
        end
        rest     = r_mask;
        rest[pick] = 1'b0;
        last     = (rest == '0);
    end

    always_comb begin
        piece           = '0;
        piece.last      = last;
        case (pick)
            KIND_LEFT: begin
                piece.piece_min_x = r_desc.bx0;
                piece.piece_min_y = r_desc.by0;
                piece.piece_max_x = r_desc.ix0;
                piece.piece_max_y = r_desc.by1;
            end
            KIND_RIGHT: begin
                piece.piece_min_x = r_desc.ix1;
                piece.piece_min_y = r_desc.by0;
                piece.piece_max_x = r_desc.bx1;
                piece.piece_max_y = r_desc.by1;
            end
            KIND_BOTTOM: begin
                piece.piece_min_x = r_desc.ix0;
                piece.piece_min_y = r_desc.by0;
                piece.piece_max_x = r_desc.ix1;
                piece.piece_max_y = r_desc.iy0;
            end
            KIND_TOP: begin
                piece.piece_min_x = r_desc.ix0;
                piece.piece_min_y = r_desc.iy1;
                piece.piece_max_x = r_desc.ix1;
                piece.piece_max_y = r_desc.by1;
            end
            KIND_WHOLE: begin
                piece.piece_min_x = r_desc.bx0;
                piece.piece_min_y = r_desc.by0;
                piece.piece_max_x = r_desc.bx1;
                piece.piece_max_y = r_desc.by1;
            end
            KIND_EMPTY: begin
                piece.empty_res = 1'b1;
            end
            default: begin
                piece.empty_res = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= emit;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= piece;
        end
        // The next item is loaded in the same cycle its predecessor's final
        // piece goes out, so pieces of consecutive items leave back to back.
        if (o_q_pop) begin
            r_desc <= i_q_desc;
            r_mask <= i_q_desc.mask;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

endmodule

// ===== hdl/rectangle_subtract.sv =====
// Rectangle subtraction: base minus cutter as up to four half-open pieces.
// Results pass the queue, the emitter's item register and the output register.
// Throughput: one result per cycle while the output is accepted; an item yields one result
// for each of the remaining pieces that the emitter walks through.
// Reset (synchronous, active low) empties the two-entry queue and the output register.
// Depends on rs_pkg, rs_front, rs_queue and rs_back.
module rectangle_subtract
    import rs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_result
);

    logic  q_full;
    logic  q_push;
    t_desc q_wr_desc;
    logic  q_pop;
    logic  q_valid;
    t_desc q_rd_desc;

    rs_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_desc   (q_wr_desc)
    );

    rs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_wr_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_rd_desc)
    );

    rs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_desc    (q_rd_desc),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule
